@@ design/pte_pkg.sv @@
// Shared types, constants and helper functions for the postfix truth table evaluator.
package pte_pkg;

    localparam int MAX_VARS_DEF    = 5;
    localparam int STACK_DEPTH_DEF = 16;

    localparam int VEC_W   = 32;
    localparam int TOK_W   = 8;
    localparam int NV_W    = 3;
    localparam int VCNT_W  = 3;
    localparam int ERR_W   = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_VEC_LSB  = 0;
    localparam int OUT_VCNT_LSB = VEC_W;
    localparam int OUT_ERR_LSB  = VEC_W + VCNT_W;
    localparam int OUT_PAD_W    = OUT_TDATA_W - VEC_W - VCNT_W - ERR_W;

    localparam logic [TOK_W-1:0] TOK_NOT  = 8'h7E;
    localparam logic [TOK_W-1:0] TOK_AND  = 8'h5E;
    localparam logic [TOK_W-1:0] TOK_OR_L = 8'h76;
    localparam logic [TOK_W-1:0] TOK_OR_U = 8'h56;
    localparam logic [TOK_W-1:0] TOK_LPAR = 8'h28;
    localparam logic [TOK_W-1:0] TOK_RPAR = 8'h29;

    localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
    localparam logic [ERR_W-1:0] ERR_UNDER = 3'd1;
    localparam logic [ERR_W-1:0] ERR_OVER  = 3'd2;
    localparam logic [ERR_W-1:0] ERR_VARS  = 3'd3;
    localparam logic [ERR_W-1:0] ERR_LEFT  = 3'd4;

    typedef struct packed {
        logic push;
        logic pop;
        logic load;
        logic clear;
    } pte_stk_cmd_t;

    // Valid-row mask for an n-variable table (n in 1..5).
    function automatic logic [VEC_W-1:0] row_mask(input logic [NV_W-1:0] n);
        logic [VEC_W:0] m;
        m = (33'd1 << (6'd1 << n)) - 33'd1;
        if (n >= 3'd5)
        begin
            return '1;
        end
        return m[VEC_W-1:0];
    endfunction

    // Column truth vector: row j is 1 when bit (n-1-col) of j is 0.
    function automatic logic [VEC_W-1:0] col_vec(input logic [NV_W-1:0] col,
                                                  input logic [NV_W-1:0] n);
        logic [VEC_W-1:0] v;
        logic [NV_W-1:0]  sh;
        logic [4:0]       jb;
        v  = '0;
        sh = n - 3'd1 - col;
        for (int j = 0; j < VEC_W; j++)
        begin
            jb = 5'(j);
            v[j] = ~jb[sh];
        end
        return v & row_mask(n);
    endfunction

endpackage

@@ design/pte_stack.sv @@
// Operand stack: top two entries in registers, the rest in a memory with a prefetched read.
module pte_stack #(
    parameter int STACK_DEPTH = pte_pkg::STACK_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  pte_pkg::pte_stk_cmd_t     cmd,
    input  logic [pte_pkg::VEC_W-1:0] wdata,
    output logic [pte_pkg::VEC_W-1:0] top,
    output logic [pte_pkg::VEC_W-1:0] second,
    output logic [$clog2(STACK_DEPTH+1)-1:0] count
);
    import pte_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [VEC_W-1:0] top_reg;
    logic [VEC_W-1:0] second_reg;
    logic [VEC_W-1:0] rd_reg;
    logic [VEC_W-1:0] mem [STACK_DEPTH];

    logic [CNT_W-1:0] wr_idx;
    logic [CNT_W-1:0] rd_idx;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic             wr_en;

    always_comb
    begin
        priority if (cmd.clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.push)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
        else
        begin
            cnt_next = cnt_reg;
        end
    end

    // third entry from the top of the next state is prefetched every cycle
    assign wr_idx  = cnt_reg - CNT_W'(2);
    assign rd_idx  = cnt_next - CNT_W'(3);
    assign wr_addr = wr_idx[AW-1:0];
    assign rd_addr = rd_idx[AW-1:0];
    assign wr_en   = cmd.push && !cmd.clear && (cnt_reg >= CNT_W'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= second_reg;
        end
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_reg <= second_reg;
        end
        else
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd.clear)
        begin
            if (cmd.push)
            begin
                second_reg <= top_reg;
                top_reg    <= wdata;
            end
            else if (cmd.pop)
            begin
                second_reg <= rd_reg;
                top_reg    <= wdata;
            end
            else if (cmd.load)
            begin
                top_reg <= wdata;
            end
        end
    end

    assign top    = top_reg;
    assign second = second_reg;
    assign count  = cnt_reg;

endmodule

@@ design/postfix_truth_table_evaluator_unit.sv @@
// Top level: postfix token stream in, truth vector per expression out.
// A result beat is registered: the final token passes the token register, then the result register.
// Throughput: one token beat per cycle, unless a final token is held (below); the stack,
// symbol table and error registers update as each token fires, so each token is resolved before the next.
// A final token waits in the token register only while the result register is full.
// Reset (rst_n, async, active low) empties stack, symbol table and error; num_vars = 1.
module postfix_truth_table_evaluator_unit #(
    parameter int MAX_VARS    = pte_pkg::MAX_VARS_DEF,
    parameter int STACK_DEPTH = pte_pkg::STACK_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [pte_pkg::NV_W-1:0]        cfg_wdata,    // num_vars
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [pte_pkg::IN_TDATA_W-1:0]  s_tdata,      // [7:0] token
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [pte_pkg::OUT_TDATA_W-1:0] m_tdata       // [31:0] truth_vector,
                                                          // [34:32] var_count,
                                                          // [37:35] error_code
);
    import pte_pkg::*;

    localparam int VAR_CAP = (MAX_VARS < 5) ? MAX_VARS : 5;
    localparam int SCNT_W  = $clog2(MAX_VARS + 1);
    localparam int SIDX_W  = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);

    logic [NV_W-1:0]        num_vars_reg;
    logic                   in_valid_reg;
    logic [TOK_W-1:0]       token_reg;
    logic                   last_reg;
    logic [TOK_W-1:0]       sym_reg [MAX_VARS];
    logic [SCNT_W-1:0]      sym_cnt_reg;
    logic [SCNT_W-1:0]      sym_cnt_next;
    logic [ERR_W-1:0]       err_reg;
    logic [ERR_W-1:0]       err_next;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [VEC_W-1:0] stk_top;
    logic [VEC_W-1:0] stk_second;
    logic [CNT_W-1:0] stk_cnt;
    pte_stk_cmd_t     cmd_raw;
    pte_stk_cmd_t     cmd;
    logic [VEC_W-1:0] stk_wdata;

    logic             out_free;
    logic             fire;
    logic [NV_W-1:0]  n_eff;
    logic             is_not;
    logic             is_bin;
    logic             is_var;
    logic             hit;
    logic [NV_W-1:0]  hit_idx;
    logic [NV_W-1:0]  col;
    logic             table_full;
    logic             sym_add;
    logic             var_bad;
    logic [VEC_W-1:0] push_val;
    logic [CNT_W-1:0] cnt_after;
    logic [VEC_W-1:0] top_after;
    logic [ERR_W-1:0] res_err;
    logic [VEC_W-1:0] res_vec;

    pte_stack #(
        .STACK_DEPTH(STACK_DEPTH)
    ) u_stack (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .wdata  (stk_wdata),
        .top    (stk_top),
        .second (stk_second),
        .count  (stk_cnt)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!last_reg || out_free);
    assign s_tready = !in_valid_reg || fire;

    always_comb
    begin
        if (num_vars_reg == '0)
        begin
            n_eff = NV_W'(1);
        end
        else if (num_vars_reg > NV_W'(VAR_CAP))
        begin
            n_eff = NV_W'(VAR_CAP);
        end
        else
        begin
            n_eff = num_vars_reg;
        end
    end

    assign is_not = (token_reg == TOK_NOT);
    assign is_bin = (token_reg == TOK_AND) || (token_reg == TOK_OR_L) || (token_reg == TOK_OR_U);
    assign is_var = !is_not && !is_bin && (token_reg != TOK_LPAR) && (token_reg != TOK_RPAR);

    // symbol lookup across the live table entries
    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < MAX_VARS; i++)
        begin
            if (!hit && (SCNT_W'(i) < sym_cnt_reg) && (sym_reg[i] == token_reg))
            begin
                hit     = 1'b1;
                hit_idx = NV_W'(i);
            end
        end
    end

    assign col        = hit ? hit_idx : NV_W'(sym_cnt_reg);
    assign table_full = (NV_W'(sym_cnt_reg) >= n_eff) || (sym_cnt_reg >= SCNT_W'(MAX_VARS));
    assign sym_add    = is_var && !hit && !table_full;
    assign var_bad    = hit ? (col >= n_eff) : table_full;
    assign push_val   = var_bad ? '0 : col_vec(col, n_eff);

    always_comb
    begin
        cmd_raw   = '0;
        stk_wdata = stk_top;
        cnt_after = stk_cnt;
        top_after = stk_top;
        err_next  = err_reg;
        if (is_not)
        begin
            if (stk_cnt == '0)
            begin
                if (err_next == ERR_NONE) err_next = ERR_UNDER;
            end
            else
            begin
                cmd_raw.load = 1'b1;
                stk_wdata    = ~stk_top;
                top_after    = ~stk_top;
            end
        end
        else if (is_bin)
        begin
            if (stk_cnt < CNT_W'(2))
            begin
                if (err_next == ERR_NONE) err_next = ERR_UNDER;
            end
            else
            begin
                cmd_raw.pop = 1'b1;
                stk_wdata   = (token_reg == TOK_AND) ? (stk_top & stk_second)
                                                     : (stk_top | stk_second);
                top_after   = stk_wdata;
                cnt_after   = stk_cnt - CNT_W'(1);
            end
        end
        else if (is_var)
        begin
            if (var_bad && (err_next == ERR_NONE)) err_next = ERR_VARS;
            if (stk_cnt >= CNT_W'(STACK_DEPTH))
            begin
                if (err_next == ERR_NONE) err_next = ERR_OVER;
            end
            else
            begin
                cmd_raw.push = 1'b1;
                stk_wdata    = push_val;
                top_after    = push_val;
                cnt_after    = stk_cnt + CNT_W'(1);
            end
        end

        res_err = err_next;
        if ((cnt_after > CNT_W'(1)) && (res_err == ERR_NONE)) res_err = ERR_LEFT;
        res_vec = ((cnt_after != '0) ? top_after : '0) & row_mask(n_eff);

        if (last_reg)
        begin
            cmd_raw       = '0;
            cmd_raw.clear = 1'b1;
        end
    end

    assign cmd          = fire ? cmd_raw : '0;
    assign sym_cnt_next = sym_cnt_reg + SCNT_W'(sym_add);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vars_reg  <= NV_W'(1);
            in_valid_reg  <= 1'b0;
            sym_cnt_reg   <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                num_vars_reg <= cfg_wdata;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (fire)
            begin
                if (last_reg)
                begin
                    sym_cnt_reg <= '0;
                    err_reg     <= ERR_NONE;
                end
                else
                begin
                    sym_cnt_reg <= sym_cnt_next;
                    err_reg     <= err_next;
                end
            end
            if (out_free)
            begin
                out_valid_reg <= fire && last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            token_reg <= s_tdata[TOK_W-1:0];
            last_reg  <= s_tlast;
        end
        if (fire && sym_add && !last_reg)
        begin
            sym_reg[sym_cnt_reg[SIDX_W-1:0]] <= token_reg;
        end
        if (fire && last_reg)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, res_err, VCNT_W'(sym_cnt_next), res_vec};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ design/pte_checker.sv @@
// Port-level checks for the evaluator, bound to the top level.
module pte_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            s_tlast,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pte_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import pte_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 2))
        else $error("result beat without a final token two cycles earlier");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_ERR_LSB +: ERR_W] <= ERR_LEFT))
        else $error("error code out of range");

    a_vcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[OUT_VCNT_LSB +: VCNT_W] <= VCNT_W'(5)))
        else $error("variable count above five");

endmodule

bind postfix_truth_table_evaluator_unit pte_checker u_pte_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb_top.sv @@
// Testbench for the postfix truth table evaluator: directed and random token streams.
module tb_top;
    import pte_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_TOKENS = 1550;
    localparam int MAX_REPORTS = 10;

    typedef logic [TOK_W-1:0] tok_t;
    typedef struct packed {
        logic [VEC_W-1:0]  vec;
        logic [VCNT_W-1:0] vcnt;
        logic [ERR_W-1:0]  err;
    } table_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [NV_W-1:0]        cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    postfix_truth_table_evaluator_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // evaluator shadow state
    logic [VEC_W-1:0] op_stack [STACK_DEPTH_DEF];
    int               op_depth;
    tok_t             sym_name [MAX_VARS_DEF];
    int               sym_used;
    logic [ERR_W-1:0] expr_err;
    logic [NV_W-1:0]  nv_reg;

    table_t pending_tables [$];
    tok_t   tok_buf [$];
    tok_t   names [8];

    int  mismatches;
    int  results_checked;
    int  tokens_sent;
    int  exprs_sent;
    int  cfg_writes;
    int  burst_left;
    int  hold_left;
    int  longest_hold;
    bit  no_gaps;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (LIMIT_CYCLES) @(posedge clk);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int eff_var_count();
        int n;
        int cap;
        cap = (MAX_VARS_DEF < 5) ? MAX_VARS_DEF : 5;
        n = int'(nv_reg);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > cap)
        begin
            n = cap;
        end
        return n;
    endfunction

    function automatic logic [VEC_W-1:0] valid_rows(input int n);
        if (n >= 5)
        begin
            return '1;
        end
        return (32'd1 << (1 << n)) - 32'd1;
    endfunction

    function automatic logic [VEC_W-1:0] column_pattern(input int col, input int n);
        logic [VEC_W-1:0] v;
        int               sh;
        v  = '0;
        sh = n - 1 - col;
        for (int j = 0; j < (1 << n); j++)
        begin
            if (((j >> sh) & 1) == 0)
            begin
                v[j] = 1'b1;
            end
        end
        return v;
    endfunction

    function automatic bit is_special(input tok_t t);
        return t == TOK_NOT || t == TOK_AND || t == TOK_OR_L || t == TOK_OR_U ||
               t == TOK_LPAR || t == TOK_RPAR;
    endfunction

    task automatic note_err(input logic [ERR_W-1:0] code);
        if (expr_err == ERR_NONE)
        begin
            expr_err = code;
        end
    endtask

    task automatic push_vec(input logic [VEC_W-1:0] v);
        if (op_depth >= STACK_DEPTH_DEF)
        begin
            note_err(ERR_OVER);
        end
        else
        begin
            op_stack[op_depth] = v;
            op_depth++;
        end
    endtask

    task automatic take_symbol(input tok_t tok, input int n);
        int col;
        col = sym_used;
        for (int i = 0; i < sym_used; i++)
        begin
            if (col == sym_used && sym_name[i] == tok)
            begin
                col = i;
            end
        end
        if (col == sym_used)
        begin
            if (sym_used >= n || sym_used >= MAX_VARS_DEF)
            begin
                note_err(ERR_VARS);
                push_vec('0);
                return;
            end
            sym_name[sym_used] = tok;
            sym_used++;
        end
        if (col >= n)
        begin
            note_err(ERR_VARS);
            push_vec('0);
        end
        else
        begin
            push_vec(column_pattern(col, n));
        end
    endtask

    // Apply one accepted token; queue the truth table when it ends an expression.
    task automatic eval_token(input tok_t tok, input logic lst);
        table_t res;
        int     n;
        n = eff_var_count();
        if (tok == TOK_NOT)
        begin
            if (op_depth < 1)
            begin
                note_err(ERR_UNDER);
            end
            else
            begin
                op_stack[op_depth-1] = ~op_stack[op_depth-1];
            end
        end
        else if (tok == TOK_AND || tok == TOK_OR_L || tok == TOK_OR_U)
        begin
            if (op_depth < 2)
            begin
                note_err(ERR_UNDER);
            end
            else
            begin
                if (tok == TOK_AND)
                begin
                    op_stack[op_depth-2] = op_stack[op_depth-1] & op_stack[op_depth-2];
                end
                else
                begin
                    op_stack[op_depth-2] = op_stack[op_depth-1] | op_stack[op_depth-2];
                end
                op_depth--;
            end
        end
        else if (tok != TOK_LPAR && tok != TOK_RPAR)
        begin
            take_symbol(tok, n);
        end
        tokens_sent++;
        if (lst)
        begin
            res.vec = (op_depth > 0) ? op_stack[op_depth-1] : '0;
            if (op_depth > 1)
            begin
                note_err(ERR_LEFT);
            end
            res.vec  = res.vec & valid_rows(n);
            res.vcnt = VCNT_W'(sym_used);
            res.err  = expr_err;
            pending_tables.push_back(res);
            op_depth = 0;
            sym_used = 0;
            expr_err = ERR_NONE;
            exprs_sent++;
        end
    endtask

    // One beat on the input side, with bursts and random gaps between them.
    task automatic send_beat(input tok_t tok, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (no_gaps)
            begin
                gap = 0;
            end
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= tok;
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        eval_token(tok, lst);
    endtask

    task automatic send_text(input string s, input bit close);
        for (int i = 0; i < s.len(); i++)
        begin
            send_beat(tok_t'(s[i]), close && (i == s.len() - 1));
        end
    endtask

    task automatic send_buf();
        for (int i = 0; i < tok_buf.size(); i++)
        begin
            send_beat(tok_buf[i], i == tok_buf.size() - 1);
        end
    endtask

    // Drop valid, let every result arrive, then let the pipeline empty.
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_tables.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_num_vars(input logic [NV_W-1:0] v);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        nv_reg = v;
        cfg_writes++;
    endtask

    task automatic pick_names(input int count);
        tok_t t;
        bit   dup;
        for (int i = 0; i < count; i++)
        begin
            do
            begin
                t = tok_t'($urandom_range(0, 255));
                dup = is_special(t);
                for (int k = 0; k < i; k++)
                begin
                    if (names[k] == t)
                    begin
                        dup = 1'b1;
                    end
                end
            end
            while (dup);
            names[i] = t;
        end
    endtask

    task automatic build_postfix(input int nnames, input int target);
        int depth;
        int pushes;
        int r;
        tok_buf.delete();
        depth  = 0;
        pushes = 0;
        while (!(pushes == target && depth == 1))
        begin
            r = $urandom_range(0, 9);
            if (pushes < target && (depth < 2 || r < 4))
            begin
                tok_buf.push_back(names[$urandom_range(0, nnames - 1)]);
                depth++;
                pushes++;
            end
            else if (depth >= 2 && r < 8)
            begin
                case ($urandom_range(0, 2))
                    0: tok_buf.push_back(TOK_AND);
                    1: tok_buf.push_back(TOK_OR_L);
                    default: tok_buf.push_back(TOK_OR_U);
                endcase
                depth--;
            end
            else if (r == 8)
            begin
                tok_buf.push_back(TOK_NOT);
            end
            else
            begin
                tok_buf.push_back(r[0] ? TOK_RPAR : TOK_LPAR);
            end
        end
    endtask

    task automatic test_basic_columns();
        send_text("a", 1);
        send_text("a~", 1);
        write_num_vars(3'd2);
        send_text("ba~^", 1);
        settle();
    endtask

    task automatic test_operators();
        write_num_vars(3'd2);
        send_text("ab^", 1);
        send_text("abv", 1);
        send_text("abV", 1);
        send_text("(ab^)~", 1);
        write_num_vars(3'd3);
        send_text("abc^v", 1);
        settle();
    endtask

    task automatic test_symbol_extremes();
        write_num_vars(3'd5);
        send_text("abcde^^^^", 1);
        write_num_vars(3'd0);
        send_text("x~", 1);
        write_num_vars(3'd7);
        send_text("pqrstvvvv", 1);
        write_num_vars(3'd2);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(TOK_AND, 1'b1);
        send_text("00^", 1);
        settle();
    endtask

    task automatic test_stack_errors();
        write_num_vars(3'd1);
        send_text("~", 1);
        send_text("a^", 1);
        send_text("(", 1);
        send_text("aa", 1);
        send_text("ab", 1);
        send_text("~aa", 1);
        for (int i = 0; i < STACK_DEPTH_DEF + 1; i++)
        begin
            send_beat(tok_t'("a"), i == STACK_DEPTH_DEF);
        end
        settle();
    endtask

    // num_vars rewritten while an expression is half done
    task automatic test_count_change();
        write_num_vars(3'd2);
        send_text("a", 0);
        write_num_vars(3'd3);
        send_text("b^", 1);
        send_text("abc", 0);
        write_num_vars(3'd1);
        send_text("ab^^^", 1);
        settle();
    endtask

    task automatic test_output_backpressure();
        write_num_vars(3'd2);
        hold_left = 600;
        longest_hold = 600;
        no_gaps = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            send_text(i[0] ? "ab^" : "a", 1);
        end
        no_gaps = 1'b0;
        settle();
    endtask

    task automatic test_random_expressions();
        logic [NV_W-1:0] sweep [8];
        int  phase;
        int  start;
        int  n;
        int  nn;
        int  r;
        int  idx;
        sweep = '{3'd1, 3'd5, 3'd0, 3'd7, 3'd3, 3'd2, 3'd4, 3'd6};
        phase = 0;
        start = tokens_sent;
        while (tokens_sent - start < RANDOM_TOKENS)
        begin
            write_num_vars((phase < 8) ? sweep[phase] : NV_W'($urandom_range(0, 7)));
            phase++;
            n = eff_var_count();
            repeat ($urandom_range(8, 20))
            begin
                r = $urandom_range(0, 99);
                nn = $urandom_range(1, n);
                if (r < 88)
                begin
                    if (r >= 75 && $urandom_range(0, 3) == 0)
                    begin
                        nn = n + 1;
                    end
                    pick_names(nn);
                    build_postfix(nn, $urandom_range(1, 12));
                    if (r >= 75)
                    begin
                        idx = $urandom_range(0, tok_buf.size() - 1);
                        case ($urandom_range(0, 2))
                            0: if (tok_buf.size() > 1) tok_buf.delete(idx);
                            1: tok_buf.insert(idx, ($urandom_range(0, 1) == 0) ? TOK_AND
                                                                                : TOK_NOT);
                            default:
                                repeat (STACK_DEPTH_DEF + $urandom_range(0, 3))
                                    tok_buf.push_front(names[0]);
                        endcase
                    end
                end
                else
                begin
                    pick_names(2);
                    tok_buf.delete();
                    repeat ($urandom_range(1, 20))
                    begin
                        case ($urandom_range(0, 4))
                            0: tok_buf.push_back(tok_t'($urandom_range(0, 255)));
                            1: tok_buf.push_back(names[$urandom_range(0, 1)]);
                            2: tok_buf.push_back(TOK_NOT);
                            3: tok_buf.push_back(($urandom_range(0, 1) == 0) ? TOK_AND
                                                                             : TOK_OR_U);
                            default: tok_buf.push_back(($urandom_range(0, 1) == 0) ? TOK_LPAR
                                                                                   : TOK_RPAR);
                        endcase
                    end
                end
                send_buf();
            end
        end
        settle();
    endtask

    // receiver: stall style is redrawn whenever style_left runs out; hold_left forces a long stall
    initial
    begin
        int rx_style;
        int style_left;
        int rx_phase;
        rx_style   = 0;
        style_left = 0;
        rx_phase   = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            rx_phase++;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (style_left == 0)
                begin
                    rx_style   = $urandom_range(0, 3);
                    style_left = $urandom_range(50, 400);
                end
                style_left--;
                case (rx_style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ((rx_phase % 5) < 2);
                    default: m_tready <= $urandom_range(0, 1);
                endcase
            end
        end
    end

    // result checker
    initial
    begin
        table_t want;
        table_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got.vec  = m_tdata[OUT_VEC_LSB +: VEC_W];
                got.vcnt = m_tdata[OUT_VCNT_LSB +: VCNT_W];
                got.err  = m_tdata[OUT_ERR_LSB +: ERR_W];
                if (pending_tables.size() == 0)
                begin
                    if (mismatches < MAX_REPORTS)
                    begin
                        $display("unexpected result beat: vec=%h vars=%0d err=%0d",
                                 got.vec, got.vcnt, got.err);
                    end
                    mismatches++;
                end
                else
                begin
                    want = pending_tables.pop_front();
                    results_checked++;
                    if (got.vec !== want.vec || got.vcnt !== want.vcnt ||
                        got.err !== want.err)
                    begin
                        if (mismatches < MAX_REPORTS)
                        begin
                            $display("result %0d: expected vec=%h vars=%0d err=%0d,",
                                     results_checked, want.vec, want.vcnt, want.err);
                            $display("    got vec=%h vars=%0d err=%0d",
                                     got.vec, got.vcnt, got.err);
                        end
                        mismatches++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        hold_left = 0;
        no_gaps   = 1'b0;
        burst_left = 0;
        op_depth  = 0;
        sym_used  = 0;
        expr_err  = ERR_NONE;
        nv_reg    = 3'd1;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_basic_columns();
        test_operators();
        test_symbol_extremes();
        test_stack_errors();
        test_count_change();
        test_output_backpressure();
        test_random_expressions();
        settle();

        $display("checked %0d truth tables from %0d expressions, %0d tokens",
                 results_checked, exprs_sent, tokens_sent);
        $display("over %0d num_vars writes, with output stalls up to %0d cycles",
                 cfg_writes, longest_hold);
        if (mismatches == 0 && pending_tables.size() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
